// ===== hw/rtl/polar_to_cartesian_defines.svh =====
// ----------------------------------------------------------------------------
// polar_to_cartesian_defines
// Assertion macros for the polar to rectangular converter.
// ----------------------------------------------------------------------------
`ifndef POLAR_TO_CARTESIAN_DEFINES_SVH
`define POLAR_TO_CARTESIAN_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define P2C_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("p2c assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define P2C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("p2c assertion failed");

`else

`define P2C_ASSERT_IMPLIES(label, ante, cons)
`define P2C_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/p2c_pkg.sv =====
// ----------------------------------------------------------------------------
// p2c_pkg
// Types, widths and the arctangent table of the polar to rectangular converter.
// ----------------------------------------------------------------------------
package p2c_pkg;

    localparam int ROTATION_STAGES = 16;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int GUARD_BITS      = 16;

    // Field widths of the items
    localparam int RADIUS_W = 15;
    localparam int ANGLE_W  = 16;

    // The arctangent table has 32 entries; more stages add nothing
    localparam int ATAN_DEPTH = 32;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 30;
    localparam int NUM_STAGES = (ROTATION_STAGES > ATAN_DEPTH) ? ATAN_DEPTH : ROTATION_STAGES;

    // Only the low SAMPLE_WIDTH-1 radius bits take part
    localparam int USED_R_W = (SAMPLE_WIDTH - 1 < RADIUS_W) ? SAMPLE_WIDTH - 1 : RADIUS_W;

    // Gain compensation, 0.6072529350 in Q31
    localparam int GAIN_FRAC_BITS = 31;
    localparam logic [GAIN_FRAC_BITS-1:0] GAIN_Q31 = 31'd1304065748;
    localparam int PROD_W  = USED_R_W + GAIN_FRAC_BITS;
    localparam int X0_SHIFT = GAIN_FRAC_BITS - GUARD_BITS;

    // x/y datapath: radius bits, guard fraction, sign and growth headroom
    localparam int DATA_W = USED_R_W + GUARD_BITS + 2;

    // Residual angle: the input angle scaled by 2^16, one bit of headroom
    localparam int Z_FRAC_BITS = 16;
    localparam int Z_W         = ANGLE_W + 1 + Z_FRAC_BITS;

    typedef struct packed {
        logic        [RADIUS_W-1:0] radius;
        logic signed [ANGLE_W-1:0]  angle;
    } p2c_polar_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x_coord;
        logic signed [SAMPLE_WIDTH-1:0] y_coord;
    } p2c_rect_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [Z_W-1:0]    z;
    } p2c_rot_t;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            5'd0:  val = 30'h20000000;
            5'd1:  val = 30'h12E4051E;
            5'd2:  val = 30'h09FB385B;
            5'd3:  val = 30'h051111D4;
            5'd4:  val = 30'h028B0D43;
            5'd5:  val = 30'h0145D7E1;
            5'd6:  val = 30'h00A2F61E;
            5'd7:  val = 30'h00517C55;
            5'd8:  val = 30'h0028BE53;
            5'd9:  val = 30'h00145F2F;
            5'd10: val = 30'h000A2F98;
            5'd11: val = 30'h000517CC;
            5'd12: val = 30'h00028BE6;
            5'd13: val = 30'h000145F3;
            5'd14: val = 30'h0000A2FA;
            5'd15: val = 30'h0000517D;
            5'd16: val = 30'h000028BE;
            5'd17: val = 30'h0000145F;
            5'd18: val = 30'h00000A30;
            5'd19: val = 30'h00000518;
            5'd20: val = 30'h0000028C;
            5'd21: val = 30'h00000146;
            5'd22: val = 30'h000000A3;
            5'd23: val = 30'h00000051;
            5'd24: val = 30'h00000029;
            5'd25: val = 30'h00000014;
            5'd26: val = 30'h0000000A;
            5'd27: val = 30'h00000005;
            5'd28: val = 30'h00000003;
            5'd29: val = 30'h00000001;
            5'd30: val = 30'h00000001;
            5'd31: val = 30'h00000000;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/p2c_prescale.sv =====
// ----------------------------------------------------------------------------
// p2c_prescale
// Gain-compensated start vector and half-turn fold of the angle.
// ----------------------------------------------------------------------------
module p2c_prescale
    import p2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  p2c_polar_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output p2c_rot_t   out_data
);

    localparam logic [PROD_W-1:0] X0_ROUND = PROD_W'(1) << (X0_SHIFT - 1);
    localparam logic signed [ANGLE_W:0] HALF_TURN = (ANGLE_W + 1)'(1) << (ANGLE_W - 1);

    logic                     valid_reg;
    logic                     valid_next;
    p2c_rot_t                 data_reg;
    p2c_rot_t                 data_next;
    p2c_rot_t                 start;
    logic                     load;
    logic [USED_R_W-1:0]      mag;
    logic [PROD_W-1:0]        prod;
    logic [PROD_W-1:0]        prod_rnd;
    logic signed [DATA_W-1:0] x_start;
    logic                     fold;
    logic signed [ANGLE_W:0]  ang_ext;
    logic signed [ANGLE_W:0]  ang_adj;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        mag      = in_data.radius[USED_R_W-1:0];
        prod     = PROD_W'(mag) * PROD_W'(GAIN_Q31);
        prod_rnd = prod + X0_ROUND;
        x_start  = $signed(DATA_W'(prod_rnd[PROD_W-1:X0_SHIFT]));

        // Outside [-pi/2, pi/2) when the two top angle bits differ
        fold    = in_data.angle[ANGLE_W-1] ^ in_data.angle[ANGLE_W-2];
        ang_ext = {in_data.angle[ANGLE_W-1], in_data.angle};

        if (fold)
        begin
            ang_adj = in_data.angle[ANGLE_W-1] ? (ang_ext + HALF_TURN) : (ang_ext - HALF_TURN);
            start.x = -x_start;
        end
        else
        begin
            ang_adj = ang_ext;
            start.x = x_start;
        end
        start.y = '0;
        start.z = {ang_adj, {Z_FRAC_BITS{1'b0}}};
    end

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = load ? start : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/p2c_rot_cell.sv =====
// ----------------------------------------------------------------------------
// p2c_rot_cell
// One shift-and-add micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module p2c_rot_cell
    import p2c_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ATAN_IDX_W-1:0] stage_idx,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  p2c_rot_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output p2c_rot_t              out_data
);

    logic                     valid_reg;
    logic                     valid_next;
    p2c_rot_t                 data_reg;
    p2c_rot_t                 data_next;
    p2c_rot_t                 rot;
    logic                     load;
    logic signed [DATA_W-1:0] x_in;
    logic signed [DATA_W-1:0] y_in;
    logic signed [Z_W-1:0]    z_in;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [Z_W-1:0]    step;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        x_in = in_data.x;
        y_in = in_data.y;
        z_in = in_data.z;
        dx   = y_in >>> stage_idx;
        dy   = x_in >>> stage_idx;
        step = $signed(Z_W'(atan_entry(stage_idx)));

        // zero residual counts as non-negative
        if (!z_in[Z_W-1])
        begin
            rot.x = x_in - dx;
            rot.y = y_in + dy;
            rot.z = z_in - step;
        end
        else
        begin
            rot.x = x_in + dx;
            rot.y = y_in - dy;
            rot.z = z_in + step;
        end
    end

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = load ? rot : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/p2c_finish.sv =====
// ----------------------------------------------------------------------------
// p2c_finish
// Round-half-up and saturation of x and y, and the output register.
// ----------------------------------------------------------------------------
module p2c_finish
    import p2c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  p2c_rot_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output p2c_rect_t out_data
);

    localparam int RND_W = DATA_W + 1 - GUARD_BITS;
    localparam int SAT_W = ((RND_W > SAMPLE_WIDTH) ? RND_W : SAMPLE_WIDTH) + 1;
    localparam logic [DATA_W:0] OUT_ROUND = (DATA_W + 1)'(1) << (GUARD_BITS - 1);
    localparam logic signed [SAT_W-1:0] SAT_POS =
        SAT_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    localparam logic signed [SAT_W-1:0] SAT_NEG = -SAT_POS;

    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [DATA_W-1:0] v
    );
        logic signed [DATA_W:0]  sum;
        logic signed [RND_W-1:0] rnd;
        logic signed [SAT_W-1:0] wide;
        sum  = (DATA_W + 1)'(v) + OUT_ROUND;
        rnd  = sum[DATA_W:GUARD_BITS];
        wide = SAT_W'(rnd);
        if (wide > SAT_POS)
        begin
            wide = SAT_POS;
        end
        else if (wide < SAT_NEG)
        begin
            wide = SAT_NEG;
        end
        return wide[SAMPLE_WIDTH-1:0];
    endfunction

    logic      valid_reg;
    logic      valid_next;
    p2c_rect_t data_reg;
    p2c_rect_t data_next;
    p2c_rect_t res;
    logic      load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        res.x_coord = round_sat(in_data.x);
        res.y_coord = round_sat(in_data.y);
        valid_next  = in_ready ? in_valid : valid_reg;
        data_next   = load ? res : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/polar_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// polar_to_cartesian: CORDIC polar to rectangular converter
// Pipeline: prescale, 16 rotation cells, output register, each registered.
// Throughput one item per cycle while rect_ready does not hold the output back.
// Reset clears only the valid flags; the converter keeps no state between items.
// ----------------------------------------------------------------------------
`include "polar_to_cartesian_defines.svh"

module polar_to_cartesian
    import p2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pol_valid,
    output logic       pol_ready,
    input  p2c_polar_t pol,
    output logic       rect_valid,
    input  logic       rect_ready,
    output p2c_rect_t  rect
);

    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MOST_NEG =
        {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    p2c_rot_t chain_data  [NUM_STAGES+1];
    logic     chain_valid [NUM_STAGES+1];
    logic     chain_ready [NUM_STAGES+1];

    p2c_prescale u_prescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pol_valid),
        .in_ready  (pol_ready),
        .in_data   (pol),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_rot
        p2c_rot_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (ATAN_IDX_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    p2c_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[NUM_STAGES]),
        .in_ready  (chain_ready[NUM_STAGES]),
        .in_data   (chain_data[NUM_STAGES]),
        .out_valid (rect_valid),
        .out_ready (rect_ready),
        .out_data  (rect)
    );

    // folded residual angle must lie in [-pi/2, pi/2)
    `P2C_ASSERT_IMPLIES(a_fold_range, chain_valid[0], (chain_data[0].z[Z_W-1:Z_W-3] == 3'b000) || (chain_data[0].z[Z_W-1:Z_W-3] == 3'b111))

    // the last rotation result handed over shows up at the output
    `P2C_ASSERT_NEXT(a_last_handoff, chain_valid[NUM_STAGES] && chain_ready[NUM_STAGES], rect_valid)

    // saturation is symmetric: the most negative code never appears
    `P2C_ASSERT_IMPLIES(a_sat_sym, rect_valid, (rect.x_coord != OUT_MOST_NEG) && (rect.y_coord != OUT_MOST_NEG))

endmodule
